// ===== rtl/core/bdc_pkg.sv =====
// Shared constants and helper functions for the business day counter.
// Holds the calendar tables, reciprocal constants and small reduction functions.
// No dependencies.
package bdc_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int COUNT_W = 22;
    localparam int DNUM_W  = 22;
    localparam int DOY_W   = 9;
    localparam int WEEK_W  = 7;
    localparam int QUOT_W  = 20;
    localparam int Q100_W  = 8;

    localparam logic [WEEK_W-1:0] WEEKEND_RESET = 7'h60;
    localparam logic [YEAR_W-1:0] YEAR_MAX      = 14'd9999;

    // floor(x / 100) == (x * RECIP100) >> RECIP100_SH for any 14-bit x
    localparam logic [12:0] RECIP100    = 13'd5243;
    localparam int          RECIP100_SH = 19;
    localparam int          PROD100_W   = YEAR_W + 13;

    // 7 * INV7 == 1 modulo 2**22: exact division of a multiple of seven
    localparam logic [DNUM_W-1:0] INV7 = 22'h1B6DB7;

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    localparam logic [DOY_W-1:0] MONTH_START [12] = '{
        9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    function automatic logic [4:0] days_in_month(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
        logic [4:0] len;
        len = 5'd0;
        if (m >= 4'd1 && m <= 4'd12)
        begin
            len = MONTH_LEN[m - 4'd1];
            if (m == 4'd2 && leap)
                len = 5'd29;
        end
        return len;
    endfunction

    function automatic logic [DOY_W-1:0] month_offset(input logic [MONTH_W-1:0] m,
                                                      input logic leap);
        logic [DOY_W-1:0] off;
        off = '0;
        if (m >= 4'd1 && m <= 4'd12)
        begin
            off = MONTH_START[m - 4'd1];
            if (leap && m > 4'd2)
                off = off + 9'd1;
        end
        return off;
    endfunction

    // 8 == 1 mod 7, so fold octal digits, then fold once more
    function automatic logic [2:0] mod7(input logic [DNUM_W-1:0] v);
        logic [23:0] x;
        logic [5:0]  s;
        logic [3:0]  t;
        x = {2'b00, v};
        s = '0;
        for (int i = 0; i < 8; i++)
            s = s + 6'(x[3*i +: 3]);
        t = 4'(s[5:3]) + 4'(s[2:0]);
        if (t >= 4'd14)
            t = t - 4'd14;
        else if (t >= 4'd7)
            t = t - 4'd7;
        return t[2:0];
    endfunction

    function automatic logic [2:0] popcount7(input logic [WEEK_W-1:0] v);
        logic [2:0] c;
        c = '0;
        for (int i = 0; i < WEEK_W; i++)
            c = c + 3'(v[i]);
        return c;
    endfunction

endpackage

// ===== rtl/core/business_day_counter.sv =====
// Business day counter: top level, six-stage pipeline.
// Depends on bdc_pkg for calendar tables and reduction helpers.
//
// Usage:
//   Drive both dates on the start_* and end_* ports and pulse start. busy is
//   always low, so a date pair is taken on every cycle that start is high.
//   After the transfer, done is high for one cycle with business_days and
//   date_error; one result per cycle at full rate.
//   The receiver cannot stall: results are shown once and then replaced.
//   Stages: year reciprocal products, leap/validity and year base, day
//   number, difference with mod-7 folding, exact divide by seven and
//   partial week, final multiply-add.
//   weekend_mask is written through cfg_valid/cfg_data (cfg_ready always
//   high) and should only change while no pair is in flight.
//   Reset clears the pipeline valid bits and sets the mask to Friday and
//   Saturday. An invalid date gives date_error high and a count of zero;
//   a start not before the end gives zero with no error.
module business_day_counter (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [4:0]                  start_day,
    input  logic [3:0]                  start_month,
    input  logic [13:0]                 start_year,
    input  logic [4:0]                  end_day,
    input  logic [3:0]                  end_month,
    input  logic [13:0]                 end_year,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [6:0]                  cfg_data,
    output logic                        done,
    output logic [21:0]                 business_days,
    output logic                        date_error
);
    import bdc_pkg::*;

    logic [WEEK_W-1:0] weekend_mask_reg;

    // stage 1
    logic                 v1_reg;
    logic [DAY_W-1:0]     d1_reg     [2];
    logic [MONTH_W-1:0]   m1_reg     [2];
    logic [YEAR_W-1:0]    y1_reg     [2];
    logic                 yok1_reg   [2];
    logic [DNUM_W-1:0]    py365_1_reg[2];
    logic [YEAR_W-3:0]    py4_1_reg  [2];
    logic [Q100_W-1:0]    qpy1_reg   [2];
    logic [Q100_W-1:0]    qy1_reg    [2];
    logic [DAY_W-1:0]     d1_next    [2];
    logic [MONTH_W-1:0]   m1_next    [2];
    logic [YEAR_W-1:0]    y1_next    [2];
    logic                 yok1_next  [2];
    logic [DNUM_W-1:0]    py365_1_next[2];
    logic [YEAR_W-3:0]    py4_1_next [2];
    logic [Q100_W-1:0]    qpy1_next  [2];
    logic [Q100_W-1:0]    qy1_next   [2];

    // stage 2
    logic                 v2_reg;
    logic                 err2_reg;
    logic [DNUM_W-1:0]    base2_reg  [2];
    logic [DOY_W-1:0]     doy2_reg   [2];
    logic                 err2_next;
    logic [DNUM_W-1:0]    base2_next [2];
    logic [DOY_W-1:0]     doy2_next  [2];

    // stage 3
    logic                 v3_reg;
    logic                 err3_reg;
    logic [DNUM_W-1:0]    day3_reg   [2];
    logic [DNUM_W-1:0]    day3_next  [2];

    // stage 4
    logic                 v4_reg;
    logic                 err4_reg;
    logic                 ok4_reg;
    logic [DNUM_W-1:0]    n4_reg;
    logic [2:0]           r4_reg;
    logic [2:0]           w4_reg;
    logic                 ok4_next;
    logic [DNUM_W-1:0]    n4_next;
    logic [2:0]           r4_next;
    logic [2:0]           w4_next;

    // stage 5
    logic                 v5_reg;
    logic                 err5_reg;
    logic                 ok5_reg;
    logic [QUOT_W-1:0]    q5_reg;
    logic [2:0]           part5_reg;
    logic [QUOT_W-1:0]    q5_next;
    logic [2:0]           part5_next;

    // stage 6 / outputs
    logic                 done_reg;
    logic [COUNT_W-1:0]   business_days_reg;
    logic                 date_error_reg;
    logic [COUNT_W-1:0]   business_days_next;

    logic                 accept;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // stage 1: split inputs, year reciprocal products
    always_comb
    begin
        logic [YEAR_W-1:0]    py;
        logic [PROD100_W-1:0] prod_py;
        logic [PROD100_W-1:0] prod_y;
        logic [YEAR_W+8:0]    p365;
        d1_next[0] = start_day;
        m1_next[0] = start_month;
        y1_next[0] = start_year;
        d1_next[1] = end_day;
        m1_next[1] = end_month;
        y1_next[1] = end_year;
        for (int i = 0; i < 2; i++)
        begin
            py      = y1_next[i] - 14'd1;
            prod_py = PROD100_W'(py) * PROD100_W'(RECIP100);
            prod_y  = PROD100_W'(y1_next[i]) * PROD100_W'(RECIP100);
            p365    = (YEAR_W+9)'(py) * (YEAR_W+9)'(365);
            yok1_next[i]    = (y1_next[i] != '0) && (y1_next[i] <= YEAR_MAX);
            py365_1_next[i] = p365[DNUM_W-1:0];
            py4_1_next[i]   = py[YEAR_W-1:2];
            qpy1_next[i]    = Q100_W'(prod_py >> RECIP100_SH);
            qy1_next[i]     = Q100_W'(prod_y >> RECIP100_SH);
        end
    end

    // stage 2: leap year, date check, days before the year and within it
    always_comb
    begin
        logic [YEAR_W:0] hund;
        logic            zero100;
        logic            leap;
        logic [4:0]      dim;
        logic            bad;
        bad = 1'b0;
        for (int i = 0; i < 2; i++)
        begin
            hund    = (YEAR_W+1)'(qy1_reg[i]) * (YEAR_W+1)'(100);
            zero100 = (hund == {1'b0, y1_reg[i]});
            leap    = (y1_reg[i][1:0] == 2'b00 && !zero100) ||
                      (zero100 && qy1_reg[i][1:0] == 2'b00);
            dim     = days_in_month(m1_reg[i], leap);
            if (!yok1_reg[i] || d1_reg[i] == '0 || d1_reg[i] > dim)
                bad = 1'b1;
            doy2_next[i]  = month_offset(m1_reg[i], leap) + DOY_W'(d1_reg[i]) - 9'd1;
            base2_next[i] = py365_1_reg[i] + DNUM_W'(py4_1_reg[i])
                            - DNUM_W'(qpy1_reg[i]) + DNUM_W'(qpy1_reg[i] >> 2);
        end
        err2_next = bad;
    end

    // stage 3: day numbers
    always_comb
    begin
        for (int i = 0; i < 2; i++)
            day3_next[i] = base2_reg[i] + DNUM_W'(doy2_reg[i]);
    end

    // stage 4: span, remainder and weekday of the start date
    always_comb
    begin
        logic [2:0] ms;
        ok4_next = !err3_reg && (day3_reg[0] < day3_reg[1]);
        n4_next  = day3_reg[1] - day3_reg[0];
        r4_next  = mod7(n4_next);
        ms       = mod7(day3_reg[0]);
        w4_next  = (ms == 3'd6) ? 3'd0 : ms + 3'd1;
    end

    // stage 5: whole weeks by exact division, business days of the partial week
    always_comb
    begin
        logic [DNUM_W-1:0]   qfull;
        logic [2*WEEK_W-1:0] dbl;
        logic [WEEK_W-1:0]   rot;
        logic [WEEK_W-1:0]   lowm;
        qfull = (n4_reg - DNUM_W'(r4_reg)) * INV7;
        q5_next = qfull[QUOT_W-1:0];
        dbl = {~weekend_mask_reg, ~weekend_mask_reg} >> w4_reg;
        rot = dbl[WEEK_W-1:0];
        for (int i = 0; i < WEEK_W; i++)
            lowm[i] = (3'(i) < r4_reg);
        part5_next = popcount7(rot & lowm);
    end

    // stage 6: weeks times business days per week plus the partial week; zero for a bad or empty span
    always_comb
    begin
        logic [QUOT_W+2:0] full;
        full = (QUOT_W+3)'(q5_reg) * (QUOT_W+3)'(popcount7(~weekend_mask_reg));
        if (ok5_reg)
            business_days_next = COUNT_W'(full) + COUNT_W'(part5_reg);
        else
            business_days_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weekend_mask_reg <= WEEKEND_RESET;
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            v3_reg           <= 1'b0;
            v4_reg           <= 1'b0;
            v5_reg           <= 1'b0;
            done_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                weekend_mask_reg <= cfg_data;
            v1_reg   <= accept;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            v5_reg   <= v4_reg;
            done_reg <= v5_reg;
        end
    end

    // payload: no reset, qualified by the valid bits
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 2; i++)
        begin
            d1_reg[i]      <= d1_next[i];
            m1_reg[i]      <= m1_next[i];
            y1_reg[i]      <= y1_next[i];
            yok1_reg[i]    <= yok1_next[i];
            py365_1_reg[i] <= py365_1_next[i];
            py4_1_reg[i]   <= py4_1_next[i];
            qpy1_reg[i]    <= qpy1_next[i];
            qy1_reg[i]     <= qy1_next[i];
            base2_reg[i]   <= base2_next[i];
            doy2_reg[i]    <= doy2_next[i];
            day3_reg[i]    <= day3_next[i];
        end
        err2_reg          <= err2_next;
        err3_reg          <= err2_reg;
        err4_reg          <= err3_reg;
        ok4_reg           <= ok4_next;
        n4_reg            <= n4_next;
        r4_reg            <= r4_next;
        w4_reg            <= w4_next;
        err5_reg          <= err4_reg;
        ok5_reg           <= ok4_reg;
        q5_reg            <= q5_next;
        part5_reg         <= part5_next;
        business_days_reg <= business_days_next;
        date_error_reg    <= err5_reg;
    end

    assign done          = done_reg;
    assign business_days = business_days_reg;
    assign date_error    = date_error_reg;

`ifndef SYNTHESIS
    // a result appears only after a matching transfer
    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 6))
        else $error("result without a matching transfer");

    // a bad date always reports a zero count
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && date_error |-> business_days == '0)
        else $error("nonzero count with date error");

    // a mask that rules out every weekday leaves nothing to count
    a_full_mask_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && weekend_mask_reg == 7'h7F |-> business_days == '0)
        else $error("nonzero count with full weekend mask");
`endif

endmodule
